[rtl/integer_to_ascii_padded_assert.svh]
// Assertion macros used by the checker of the integer formatter.
`ifndef INTEGER_TO_ASCII_PADDED_ASSERT_SVH
`define INTEGER_TO_ASCII_PADDED_ASSERT_SVH

// Implication into the next cycle, checked outside reset.
`define ITOAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("integer formatter check failed");

// Same-cycle implication, checked outside reset.
`define ITOAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("integer formatter check failed");

// Implication into the next cycle that also holds while reset is applied.
`define ITOAP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("integer formatter reset check failed");

`endif

[rtl/itoap_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package itoap_pkg;

  // Size of the text buffer; the field width is clamped to one less.
  localparam int BUFFER_SIZE = 64;
  localparam int WIDTH_W     = $clog2(BUFFER_SIZE);

  localparam int VALUE_W   = 64;
  localparam int FIELD_W   = 8;
  localparam int CHAR_W    = 7;
  localparam int NIB_W     = 4;
  // A 64-bit magnitude needs at most 20 decimal digits.
  localparam int DIGITS    = 20;
  localparam int DIG_W     = DIGITS * NIB_W;
  localparam int ND_W      = $clog2(DIGITS + 1);
  localparam int CONV_W    = $clog2(VALUE_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [NIB_W-1:0]  RADIX_DEC = 4'd10;

  // One converted number, digits left-justified (most significant on top).
  typedef struct packed {
    logic [DIG_W-1:0]   digits;
    logic [ND_W-1:0]    nd;
    logic [WIDTH_W-1:0] width;
    logic               neg;
    logic               zpad;
  } item_t;

  // ASCII for one digit of radix 10 or 16, upper-case letters.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < RADIX_DEC) begin
      c = CH_ZERO + CHAR_W'(nib);
    end else begin
      c = CH_UPPER + CHAR_W'(nib - RADIX_DEC);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/itoap_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module itoap_queue
  import itoap_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_data,
  output logic       full,
  input  wire logic  pop,
  output item_t      pop_data,
  output logic       empty
);

  item_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/itoap_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module itoap_front
  import itoap_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               is_signed,
  input  wire logic               base_hex,
  input  wire logic               zero_fill,
  input  wire logic [FIELD_W-1:0] field_width,
  input  wire logic               push,
  output logic                    full,
  output logic                    q_push,
  output item_t                   q_data,
  input  wire logic               q_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_CONV = 4'b0010,
    F_NORM = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t       state_r, state_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [DIG_W-1:0]   digits_r, digits_nxt;
  logic [ND_W-1:0]    nd_r, nd_nxt;
  logic [WIDTH_W-1:0] width_r, width_nxt;
  logic               neg_r, neg_nxt;
  logic               zpad_r, zpad_nxt;
  logic [CONV_W-1:0]  cnt_r, cnt_nxt;
  logic [DIG_W-1:0]   bcd_adj;
  logic               in_neg;

  assign full   = (state_r != F_IDLE);
  assign q_push = (state_r == F_PUSH) && !q_full;
  assign in_neg = !base_hex && is_signed && value[VALUE_W-1];

  assign q_data.digits = digits_r;
  assign q_data.nd     = nd_r;
  assign q_data.width  = width_r;
  assign q_data.neg    = neg_r;
  assign q_data.zpad   = zpad_r;

  // Shift-and-add-3 correction: every BCD digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (digits_r[i*NIB_W +: NIB_W] >= 4'd5) begin
        bcd_adj[i*NIB_W +: NIB_W] = digits_r[i*NIB_W +: NIB_W] + 4'd3;
      end else begin
        bcd_adj[i*NIB_W +: NIB_W] = digits_r[i*NIB_W +: NIB_W];
      end
    end
  end

  // Sequencer: accept, convert a decimal magnitude one bit per cycle, left-justify, hand over.
  always_comb begin
    state_nxt  = state_r;
    mag_nxt    = mag_r;
    digits_nxt = digits_r;
    nd_nxt     = nd_r;
    width_nxt  = width_r;
    neg_nxt    = neg_r;
    zpad_nxt   = zpad_r;
    cnt_nxt    = cnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (push) begin
          neg_nxt  = in_neg;
          zpad_nxt = zero_fill;
          nd_nxt   = ND_W'(DIGITS);
          mag_nxt  = in_neg ? (~value + 1'b1) : value;
          if ({1'b0, field_width} >= (FIELD_W + 1)'(BUFFER_SIZE)) begin
            width_nxt = WIDTH_W'(BUFFER_SIZE - 1);
          end else begin
            width_nxt = WIDTH_W'(field_width);
          end
          if (base_hex) begin
            digits_nxt = {{(DIG_W - VALUE_W){1'b0}}, value};
            state_nxt  = F_NORM;
          end else begin
            digits_nxt = '0;
            cnt_nxt    = CONV_W'(VALUE_W - 1);
            state_nxt  = F_CONV;
          end
        end
      end
      F_CONV: begin
        digits_nxt = {bcd_adj[DIG_W-2:0], mag_r[VALUE_W-1]};
        mag_nxt    = {mag_r[VALUE_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = F_NORM;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      F_NORM: begin
        // Drop leading zero digits, keeping at least one.
        if ((digits_r[DIG_W-1 -: NIB_W] == '0) && (nd_r != ND_W'(1))) begin
          digits_nxt = {digits_r[DIG_W-NIB_W-1:0], {NIB_W{1'b0}}};
          nd_nxt     = nd_r - 1'b1;
        end else begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers need no reset.
  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    digits_r <= digits_nxt;
    nd_r     <= nd_nxt;
    width_r  <= width_nxt;
    neg_r    <= neg_nxt;
    zpad_r   <= zpad_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

`default_nettype wire

[rtl/itoap_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module itoap_back
  import itoap_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire item_t             q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic [CHAR_W-1:0]      character,
  output logic                   last,
  output logic                   empty,
  input  wire logic              pop
);

  logic               busy_r, busy_nxt;
  logic [DIG_W-1:0]   digits_r, digits_nxt;
  logic [ND_W-1:0]    nd_r, nd_nxt;
  logic [WIDTH_W-1:0] pre_r, pre_nxt;
  logic               first_r, first_nxt;
  logic               neg_r, neg_nxt;
  logic               zpad_r, zpad_nxt;
  logic [WIDTH_W-1:0] body_len;
  logic [WIDTH_W-1:0] pre_len;
  logic               take;
  logic               sign_here;

  assign empty = !busy_r;
  assign last  = (pre_r == '0) && (nd_r == ND_W'(1));
  assign take  = busy_r && pop;
  assign q_pop = !q_empty && (!busy_r || (take && last));

  // Prefix ahead of the digits: padding plus sign, at least the sign.
  assign body_len = WIDTH_W'(q_data.nd) + WIDTH_W'(q_data.neg);
  assign pre_len  = ((q_data.width > body_len) ? (q_data.width - body_len) : '0)
                    + WIDTH_W'(q_data.neg);

  // The sign leads zero padding, and closes space padding.
  assign sign_here = neg_r && ((zpad_r && first_r) || (!zpad_r && (pre_r == WIDTH_W'(1))));

  always_comb begin
    if (pre_r != '0) begin
      if (sign_here) begin
        character = CH_MINUS;
      end else begin
        character = zpad_r ? CH_ZERO : CH_SPACE;
      end
    end else begin
      character = digit_char(digits_r[DIG_W-1 -: NIB_W]);
    end
  end

  // Load the next number or step through the current one on each transfer.
  always_comb begin
    busy_nxt   = busy_r;
    digits_nxt = digits_r;
    nd_nxt     = nd_r;
    pre_nxt    = pre_r;
    first_nxt  = first_r;
    neg_nxt    = neg_r;
    zpad_nxt   = zpad_r;
    if (q_pop) begin
      busy_nxt   = 1'b1;
      digits_nxt = q_data.digits;
      nd_nxt     = q_data.nd;
      pre_nxt    = pre_len;
      first_nxt  = 1'b1;
      neg_nxt    = q_data.neg;
      zpad_nxt   = q_data.zpad;
    end else if (take) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else if (pre_r != '0) begin
        pre_nxt   = pre_r - 1'b1;
        first_nxt = 1'b0;
      end else begin
        digits_nxt = {digits_r[DIG_W-NIB_W-1:0], {NIB_W{1'b0}}};
        nd_nxt     = nd_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
    nd_r     <= nd_nxt;
    pre_r    <= pre_nxt;
    first_r  <= first_nxt;
    neg_r    <= neg_nxt;
    zpad_r   <= zpad_nxt;
  end

endmodule

`default_nettype wire

[rtl/integer_to_ascii_padded.sv]
// Decimal input passes through the 64-step shift-and-add-3 converter and the one-digit-per-cycle
// leading-zero trim; hex input skips the converter and goes straight to the trim.
// Throughput: one character per cycle while pop is held; a two-entry queue lets conversion of
// the next number overlap emission of the current one.
// Reset (rst_n low, synchronous) empties the queue and idles both parts; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_padded
  import itoap_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic               in_is_signed,
  input  wire logic               in_base_hex,
  input  wire logic               in_zero_fill,
  input  wire logic [FIELD_W-1:0] in_field_width,
  input  wire logic               push,
  output logic                    full,
  output logic [CHAR_W-1:0]       out_character,
  output logic                    out_last,
  output logic                    empty,
  input  wire logic               pop
);

  item_t fq_data;
  item_t qb_data;
  logic  fq_push;
  logic  fq_full;
  logic  qb_pop;
  logic  qb_empty;

  // Front: accepts items and converts them to left-justified digit strings.
  itoap_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .value       (in_value),
    .is_signed   (in_is_signed),
    .base_hex    (in_base_hex),
    .zero_fill   (in_zero_fill),
    .field_width (in_field_width),
    .push        (push),
    .full        (full),
    .q_push      (fq_push),
    .q_data      (fq_data),
    .q_full      (fq_full)
  );

  // Queue of converted numbers between the two parts.
  itoap_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_data),
    .full      (fq_full),
    .pop       (qb_pop),
    .pop_data  (qb_data),
    .empty     (qb_empty)
  );

  // Back: emits padding, sign and digits one character per transfer.
  itoap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (qb_data),
    .q_empty   (qb_empty),
    .q_pop     (qb_pop),
    .character (out_character),
    .last      (out_last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

[rtl/itoap_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_ascii_padded_assert.svh"

module itoap_checker
  import itoap_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic              full,
  input  wire logic [CHAR_W-1:0] out_character,
  input  wire logic              out_last,
  input  wire logic              empty,
  input  wire logic              pop
);

  logic          char_ok;
  logic [CHAR_W:0] out_word;

  // Only digits, upper-case hex letters, the minus sign and spaces are ever shown.
  assign char_ok = ((out_character >= CH_ZERO) && (out_character <= CH_ZERO + 7'd9))
                || ((out_character >= CH_UPPER) && (out_character <= CH_UPPER + 7'd5))
                || (out_character == CH_MINUS)
                || (out_character == CH_SPACE);

  // The current character and its last flag as shown on the output ports.
  assign out_word = {out_character, out_last};

  // Reset leaves both sides idle.
  `ITOAP_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, empty && !full)

  `ITOAP_ASSERT_NOW(a_char_legal, clk, rst_n, !empty, char_ok)

  // A waiting character holds until its transfer.
  `ITOAP_ASSERT_NEXT(a_stall_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_word))

  // The front stays busy with an accepted number, so it refuses the next one.
  `ITOAP_ASSERT_NEXT(a_in_busy, clk, rst_n, push && !full, full)

endmodule

bind integer_to_ascii_padded itoap_checker u_itoap_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .out_character (out_character),
  .out_last      (out_last),
  .empty         (empty),
  .pop           (pop)
);

`default_nettype wire
